[design/two_level_logic_minimizer_macros.svh]
// Assertion macros used by the checker file.
`ifndef TWO_LEVEL_LOGIC_MINIMIZER_MACROS_SVH
`define TWO_LEVEL_LOGIC_MINIMIZER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define TLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[design/tlm_pkg.sv]
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and helpers of the two-level logic minimizer.
// ----------------------------------------------------------------------------
package tlm_pkg;
	localparam int MaxVars = 6;
	localparam int NumTerms = 1 << MaxVars;
	localparam int NumCubes = 729;
	localparam int CubeIdxW = 10;
	localparam int PickW = 7;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_DC = 2'd1,
		CMD_SOLVE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_NUM_VARS = 1'b0,
		REG_MAXTERM = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PRIME, ST_ESS, ST_ESS_PICK, ST_GREEDY, ST_GREEDY_END,
		ST_OUT_RD, ST_OUT
	} state_t;

	// Solver control to the pick memory.
	typedef struct packed {
		logic wr_en;
		logic [PickW-2:0] wr_addr;
		logic [2*MaxVars-1:0] wr_data;
	} pick_wr_t;

	// Set of minterms covered by a cube over n variables.
	function automatic logic [NumTerms-1:0] cube_cover(input logic [MaxVars-1:0] ones,
		input logic [MaxVars-1:0] dashes, input logic [MaxVars-1:0] vm);
		logic [NumTerms-1:0] cov;
		logic [MaxVars-1:0] t;
		cov = '0;
		for (int i = 0; i < NumTerms; i++) begin
			t = MaxVars'(i);
			if ((t & ~vm) == '0 && ((t & ~dashes & vm) == ones))
				cov[i] = 1'b1;
		end
		return cov;
	endfunction

	function automatic logic [PickW-1:0] popc(input logic [NumTerms-1:0] x);
		logic [PickW-1:0] s [NumTerms];
		for (int i = 0; i < NumTerms; i++)
			s[i] = PickW'(x[i]);
		// Pairwise adder tree, six levels deep.
		for (int w = NumTerms >> 1; w >= 1; w = w >> 1)
			for (int i = 0; i < w; i++)
				s[i] = s[2*i] + s[2*i+1];
		return s[0];
	endfunction
endpackage

[design/two_level_logic_minimizer.sv]
// ----------------------------------------------------------------------------
// two_level_logic_minimizer
// Term store and prime/cover solver with streamed cube output.
// ----------------------------------------------------------------------------
// channel   | dir | fields
// s_axis    | in  | tuser: cmd[1:0]; tdata: term[5:0]
// m_axis    | out | tdata: cube_ones[5:0] cube_dashes[11:6]; tuser: cover_empty; tlast
// apb       | in  | num_vars @0, maxterm_mode @4
// A solve walks all 4096 (ones, dashes) pairs per pass, one per cycle: one pass for
// primes, one to count the primes over each term, one to list the essentials, then
// one greedy pass per pick plus a final one, each followed by a decision state; each
// result is then read from the pick memory and emitted on m_axis.
// Reset clears control and listed/dc/unc bitmaps; memories are written before read.
// Output stalls hold the sequencer in its emit state.
module two_level_logic_minimizer import tlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // term[5:0]
	input logic [1:0] s_axis_tuser, // cmd[1:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // cube_ones[5:0], cube_dashes[11:6]
	output logic m_axis_tuser, // cover_empty
	output logic m_axis_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	state_t state_q, state_d;
	logic [2:0] num_vars_q;
	logic maxterm_q;
	logic [NumTerms-1:0] listed_q, dc_q, on_q, care_q, unc_q;
	logic [2*MaxVars-1:0] pair_q, pair_s1;
	logic walk_s1;
	logic [PickW-1:0] pick_cnt_q, out_idx_q, best_q;
	logic [2*MaxVars-1:0] best_cube_q;
	// per term: prime count saturated at 2 and the last prime hit
	logic [1:0] hit_cnt_q [NumTerms];
	logic [2*MaxVars-1:0] hit_cube_q [NumTerms];
	logic [NumTerms-1:0] ess_term_q;

	logic [MaxVars-1:0] vm, ones, dashes, ones1, dash1;
	logic [2*MaxVars-1:0] cube_w, cube_s1;
	logic ess_hit;
	logic [2:0] n_eff;
	logic [CubeIdxW-1:0] cidx;
	logic prime_rd, prime_wr, pair_valid, pair_last;
	logic [NumTerms-1:0] cov1;
	pick_wr_t pick_wr;
	logic [2*MaxVars-1:0] pick_rd;
	logic s_fire, cfg_wr;
	logic [1:0] cmd;
	logic [5:0] term;

	assign n_eff = (num_vars_q == 3'd0) ? 3'd1 : (num_vars_q > 3'(MaxVars)) ? 3'(MaxVars)
		: num_vars_q;
	assign vm = MaxVars'((7'd1 << n_eff) - 7'd1);
	// The walk steps dashes fastest so cubes come in (ones, dashes) order.
	assign ones = pair_q[2*MaxVars-1:MaxVars];
	assign dashes = pair_q[MaxVars-1:0];
	assign cube_w = {dashes, ones};
	assign pair_valid = ((ones & dashes) == '0) && ((ones & ~vm) == '0)
		&& ((dashes & ~vm) == '0);
	assign pair_last = (pair_q == '1);

	always_comb begin
		cidx = '0;
		for (int i = MaxVars - 1; i >= 0; i--)
			cidx = CubeIdxW'(cidx * 3 + (dashes[i] ? 2 : (ones[i] ? 1 : 0)));
	end

	// primality: cube inside care set and no single-variable expansion is
	always_comb begin
		prime_wr = ((cube_cover(ones, dashes, vm) & ~care_q) == '0);
		for (int i = 0; i < MaxVars; i++)
			if (vm[i] && !dashes[i] &&
				((cube_cover(ones & ~(MaxVars'(1) << i), dashes | (MaxVars'(1) << i), vm)
				& ~care_q) == '0))
				prime_wr = 1'b0;
	end

	assign ones1 = pair_s1[2*MaxVars-1:MaxVars];
	assign dash1 = pair_s1[MaxVars-1:0];
	assign cube_s1 = {dash1, ones1};
	assign cov1 = cube_cover(ones1, dash1, vm);

	tlm_prime_ram u_prime (
		.clk(clk), .wr_en(state_q == ST_PRIME && pair_valid), .wr_addr(cidx),
		.wr_data(prime_wr), .rd_addr(cidx), .rd_data(prime_rd)
	);

	tlm_pick_ram u_pick (.clk(clk), .wr(pick_wr), .rd_addr(out_idx_q[PickW-2:0]),
		.rd_data(pick_rd));

	assign cmd = s_axis_tuser;
	assign term = s_axis_tdata[5:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_MAXTERM) ? {31'd0, maxterm_q} : {29'd0, num_vars_q};

	// ess term index sweep in ST_ESS_PICK reuses pair_q as cube walk
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_fire && cmd == CMD_SOLVE) state_d = ST_PRIME;
			ST_PRIME: if (pair_last) state_d = ST_ESS;
			ST_ESS: if (pair_last) state_d = ST_ESS_PICK;
			ST_ESS_PICK: if (pair_last) state_d = ST_GREEDY;
			ST_GREEDY: if (pair_last) state_d = ST_GREEDY_END;
			ST_GREEDY_END: state_d = (best_q == '0 || unc_q == '0 || pick_cnt_q[PickW-1])
				? ST_OUT_RD : ST_GREEDY;
			ST_OUT_RD: state_d = ST_OUT;
			ST_OUT: if (m_axis_tready)
				state_d = (pick_cnt_q == '0 || out_idx_q + 7'd1 >= pick_cnt_q) ? ST_IDLE
					: ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// The current cube is the sole prime of some on-set term.
	always_comb begin
		ess_hit = 1'b0;
		for (int t = 0; t < NumTerms; t++)
			if (ess_term_q[t] && hit_cube_q[t] == cube_w)
				ess_hit = 1'b1;
	end

	always_comb begin
		pick_wr = '0;
		if (state_q == ST_ESS_PICK && pair_valid) begin
			pick_wr.wr_en = ess_hit && !pick_cnt_q[PickW-1];
			pick_wr.wr_addr = pick_cnt_q[PickW-2:0];
			pick_wr.wr_data = cube_w;
		end else if (state_q == ST_GREEDY_END && best_q != '0 && unc_q != '0
			&& !pick_cnt_q[PickW-1]) begin
			pick_wr.wr_en = 1'b1;
			pick_wr.wr_addr = pick_cnt_q[PickW-2:0];
			pick_wr.wr_data = best_cube_q;
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = (pick_cnt_q == '0) ? 16'h0000 : {4'd0, pick_rd};
	assign m_axis_tuser = (pick_cnt_q == '0);
	assign m_axis_tlast = (pick_cnt_q == '0) || (out_idx_q + 7'd1 >= pick_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_vars_q <= 3'd4;
			maxterm_q <= 1'b0;
			listed_q <= '0;
			dc_q <= '0;
			unc_q <= '0;
			pick_cnt_q <= '0;
			pair_q <= '0;
			walk_s1 <= 1'b0;
			out_idx_q <= '0;
		end else begin
			state_q <= state_d;
			walk_s1 <= (state_q == ST_ESS || state_q == ST_GREEDY) && pair_valid;
			if (cfg_wr) begin
				if (paddr[2] == REG_NUM_VARS) num_vars_q <= pwdata[2:0];
				else maxterm_q <= pwdata[0];
			end
			if (s_fire && {2'b0, term} <= {2'b0, vm}) begin
				if (cmd == CMD_LOAD) listed_q[term] <= 1'b1;
				if (cmd == CMD_DC) dc_q[term] <= 1'b1;
			end
			if (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_OUT_RD
				&& state_q != ST_GREEDY_END)
				pair_q <= pair_q + 1'b1;
			if (s_fire && cmd == CMD_SOLVE) begin
				pair_q <= '0;
				pick_cnt_q <= '0;
				out_idx_q <= '0;
				listed_q <= '0;
				dc_q <= '0;
				unc_q <= maxterm_q ? (cube_cover('0, vm, vm) & ~(listed_q | dc_q))
					: (listed_q & cube_cover('0, vm, vm));
			end
			if (state_q == ST_ESS_PICK && pair_valid && ess_hit) begin
				pick_cnt_q <= pick_cnt_q + (pick_cnt_q[PickW-1] ? 7'd0 : 7'd1);
				unc_q <= unc_q & ~cube_cover(ones, dashes, vm);
			end
			if (state_q == ST_GREEDY_END) begin
				if (pick_wr.wr_en) begin
					pick_cnt_q <= pick_cnt_q + 1'b1;
					unc_q <= unc_q & ~cube_cover(best_cube_q[MaxVars-1:0],
						best_cube_q[2*MaxVars-1:MaxVars], vm);
				end
			end
			if (state_q == ST_OUT && m_axis_tready)
				out_idx_q <= out_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1 <= pair_q;
		if (s_fire && cmd == CMD_SOLVE) begin
			on_q <= maxterm_q ? (cube_cover('0, vm, vm) & ~(listed_q | dc_q))
				: (listed_q & cube_cover('0, vm, vm));
			care_q <= maxterm_q ? cube_cover('0, vm, vm) & (~listed_q | dc_q)
				: (listed_q | dc_q) & cube_cover('0, vm, vm);
			for (int t = 0; t < NumTerms; t++) hit_cnt_q[t] <= '0;
		end
		if (state_q == ST_ESS && walk_s1 == 1'b0 && pair_q == '0)
			for (int t = 0; t < NumTerms; t++) hit_cnt_q[t] <= '0;
		// essential scan: the memory read of the previous pair lands now
		if ((state_q == ST_ESS || state_q == ST_ESS_PICK) && walk_s1 && prime_rd)
			for (int t = 0; t < NumTerms; t++)
				if (cov1[t]) begin
					if (hit_cnt_q[t] != 2'd2) hit_cnt_q[t] <= hit_cnt_q[t] + 1'b1;
					hit_cube_q[t] <= cube_s1;
				end
		// All counts are final before the last pair of the counting pass.
		if (state_q == ST_ESS && pair_last)
			for (int t = 0; t < NumTerms; t++)
				ess_term_q[t] <= on_q[t] && hit_cnt_q[t] == 2'd1;
		if (state_q == ST_GREEDY && pair_q == '0) best_q <= '0;
		if ((state_q == ST_GREEDY || state_q == ST_GREEDY_END) && walk_s1 && prime_rd
			&& popc(cov1 & unc_q) > ((state_q == ST_GREEDY && pair_q == '0) ? '0 : best_q))
		begin
			best_q <= popc(cov1 & unc_q);
			best_cube_q <= cube_s1;
		end
	end
endmodule

[design/tlm_prime_ram.sv]
// ----------------------------------------------------------------------------
// tlm_prime_ram
// One-bit prime flag memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module tlm_prime_ram import tlm_pkg::*; (
	input logic clk,
	input logic wr_en,
	input logic [CubeIdxW-1:0] wr_addr,
	input logic wr_data,
	input logic [CubeIdxW-1:0] rd_addr,
	output logic rd_data
);
	logic mem [NumCubes];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

[design/tlm_pick_ram.sv]
// ----------------------------------------------------------------------------
// tlm_pick_ram
// Cover list memory: one cube per entry, ones in the low half.
// ----------------------------------------------------------------------------
module tlm_pick_ram import tlm_pkg::*; (
	input logic clk,
	input pick_wr_t wr,
	input logic [PickW-2:0] rd_addr,
	output logic [2*MaxVars-1:0] rd_data
);
	logic [2*MaxVars-1:0] mem [NumTerms];

	always_ff @(posedge clk) begin
		if (wr.wr_en)
			mem[wr.wr_addr] <= wr.wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

[design/tlm_checker.sv]
// ----------------------------------------------------------------------------
// tlm_checker
// Port-level checks of the minimizer.
// ----------------------------------------------------------------------------
`include "two_level_logic_minimizer_macros.svh"
module tlm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tuser,
	input logic pready
);
	`TLM_ASSERT_IMP(a_busy_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`TLM_ASSERT_IMP(a_empty_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[11:0] == 12'd0)
	`TLM_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`TLM_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind two_level_logic_minimizer tlm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser), .pready(pready));
